>>> rtl/rti_pkg.sv
`default_nettype none

package rti_pkg;

  // Coordinate and derived operand widths.
  localparam int CW = 24;            // input coordinates, 8 fraction bits
  localparam int EW = CW + 1;        // edge and origin offset vectors
  localparam int PW = 2 * EW + 1;    // cross product components
  localparam int PLW = 26;           // low part of a cross component in the dot products
  localparam int PHW = PW - PLW;     // high part, signed
  localparam int AW = 80;            // determinant and numerators
  localparam int RW = 112;           // divider remainder and shifted divisor
  localparam int SQW = 40;           // magnitude range of the squared determinant path
  localparam int SQH = SQW / 2;
  localparam int LW = 2 * SQW + 1;   // det squared and eps squared times |d|^2
  localparam int DDW = 50;           // |d|^2
  localparam int DDL = 25;           // low part of |d|^2 in the threshold product

  localparam int TW = 32;            // distance window and t quotient
  localparam int UQW = 17;           // barycentric quotients
  localparam int FRAC = 16;          // output fraction bits
  localparam int XW = TW + 2;        // rounded t with headroom

  localparam int GEOM_STAGES = 6;
  localparam int CLASS_STAGES = 4;
  localparam int DIV_STEPS = TW;
  localparam int NSTG = GEOM_STAGES + CLASS_STAGES + DIV_STEPS + 1;

  localparam int unsigned EPS_DEFAULT = 1;

  localparam int IDXW = 4;
  localparam int DATAW = 32;

  typedef enum logic [IDXW-1:0] {
    REG_ORIGIN_X = 4'd0,
    REG_ORIGIN_Y = 4'd1,
    REG_ORIGIN_Z = 4'd2,
    REG_DIR_X    = 4'd3,
    REG_DIR_Y    = 4'd4,
    REG_DIR_Z    = 4'd5,
    REG_MIN_DIST = 4'd6,
    REG_MAX_DIST = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_t;

  // Exact determinant and the three numerators.
  typedef struct packed {
    logic signed [AW-1:0] det;
    logic signed [AW-1:0] un;
    logic signed [AW-1:0] vn;
    logic signed [AW-1:0] tn;
  } geom_t;

  // State of the three divider lanes as it travels down the pipe.
  typedef struct packed {
    logic          miss;
    logic          tneg;
    logic [AW-1:0] dvs;
    logic [RW-1:0] ru;
    logic [RW-1:0] rv;
    logic [RW-1:0] rt;
    logic [UQW-1:0] qu;
    logic [UQW-1:0] qv;
    logic [TW-1:0] qt;
  } div_t;

endpackage

`default_nettype wire

>>> rtl/ray_triangle_intersect_core.sv
// Moller-Trumbore ray/triangle test, one triangle per input beat.
// The ray (origin, unnormalised direction, distance window) sits in eight
// configuration registers, written through the cfg channel; the user must
// write them only while the core is idle, as the core does not enforce it.
// cfg_ready is always high; indices outside the register list are ignored.
// Each input beat carries three vertices and yields exactly one output beat:
// hit, hit_distance (Q15.16) and bary_u / bary_v (Q1.16), all zero on a miss.
// The datapath is a fixed pipeline of 43 register stages: six for the exact
// cross and dot products, four for the sign fold, bound tests and the
// parallel test, 32 restoring division steps (one quotient bit per stage for
// t, shared with u and v for their lowest 17 bits), and the output register.
// Throughput is one triangle per cycle while the receiver takes results.
// The whole pipe advances together. When out_valid is high and out_ready is
// low, every stage holds and in_ready drops in the same cycle, so nothing is
// lost or repeated. Reset clears every valid bit and restores the register
// defaults: origin zero, direction (0, 0, 1), window [0, max].
// The eps squared times |d|^2 threshold is recomputed from the registers via
// dsq, dd, th_lo/th_hi and par_thresh, well before an item reaches the test.
`default_nettype none

module ray_triangle_intersect_core #(
  parameter int unsigned PARALLEL_EPS = rti_pkg::EPS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rti_pkg::IDXW-1:0]    cfg_index,
  input  logic [rti_pkg::DATAW-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [rti_pkg::CW-1:0] vertex0_x,
  input  logic signed [rti_pkg::CW-1:0] vertex0_y,
  input  logic signed [rti_pkg::CW-1:0] vertex0_z,
  input  logic signed [rti_pkg::CW-1:0] vertex1_x,
  input  logic signed [rti_pkg::CW-1:0] vertex1_y,
  input  logic signed [rti_pkg::CW-1:0] vertex1_z,
  input  logic signed [rti_pkg::CW-1:0] vertex2_x,
  input  logic signed [rti_pkg::CW-1:0] vertex2_y,
  input  logic signed [rti_pkg::CW-1:0] vertex2_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic signed [rti_pkg::TW-1:0] hit_distance,
  output logic [rti_pkg::UQW-1:0]     bary_u,
  output logic [rti_pkg::UQW-1:0]     bary_v
);
  import rti_pkg::*;

  localparam logic [63:0] EPS_W = 64'(PARALLEL_EPS);
  localparam logic [31:0] EPS2  = 32'(EPS_W * EPS_W);

  // Configuration registers.
  vec_t                 org;
  vec_t                 dir;
  logic signed [TW-1:0] tmin;
  logic signed [TW-1:0] tmax;

  logic       adv;
  logic [NSTG-1:0] vld;

  // Parallel threshold path.
  logic signed [2*CW-1:0] dsq [3];
  logic [DDW-1:0]         dd;
  logic [DDL+31:0]        th_lo;
  logic [DDW-DDL+31:0]    th_hi;
  logic [LW-1:0]          par_thresh;

  vec_t  v0, v1, v2;
  geom_t geom;
  div_t  chain [DIV_STEPS+1];

  logic                 rest;
  logic [XW-1:0]        qx;
  logic signed [XW-1:0] tf, tc;
  logic                 win_ok;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      org  <= '0;
      dir  <= '{x: '0, y: '0, z: CW'(256)};
      tmin <= '0;
      tmax <= {1'b0, {(TW-1){1'b1}}};
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X: org.x <= cfg_data[CW-1:0];
        REG_ORIGIN_Y: org.y <= cfg_data[CW-1:0];
        REG_ORIGIN_Z: org.z <= cfg_data[CW-1:0];
        REG_DIR_X:    dir.x <= cfg_data[CW-1:0];
        REG_DIR_Y:    dir.y <= cfg_data[CW-1:0];
        REG_DIR_Z:    dir.z <= cfg_data[CW-1:0];
        REG_MIN_DIST: tmin  <= cfg_data[TW-1:0];
        REG_MAX_DIST: tmax  <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // eps^2 * |d|^2, with |d|^2 split in halves so each product is 25 by 32 bits.
  always_ff @(posedge clk) begin
    dsq[0]     <= dir.x * dir.x;
    dsq[1]     <= dir.y * dir.y;
    dsq[2]     <= dir.z * dir.z;
    dd         <= DDW'($unsigned(dsq[0])) + DDW'($unsigned(dsq[1]))
                  + DDW'($unsigned(dsq[2]));
    th_lo      <= dd[DDL-1:0] * EPS2;
    th_hi      <= dd[DDW-1:DDL] * EPS2;
    par_thresh <= (LW'(th_hi) << DDL) + LW'(th_lo);
  end

  // Valid bits move with the data; the whole pipe holds on a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  assign v0 = '{x: vertex0_x, y: vertex0_y, z: vertex0_z};
  assign v1 = '{x: vertex1_x, y: vertex1_y, z: vertex1_z};
  assign v2 = '{x: vertex2_x, y: vertex2_y, z: vertex2_z};

  rti_geom u_geom (
    .clk  (clk),
    .en   (adv),
    .v0   (v0),
    .v1   (v1),
    .v2   (v2),
    .org  (org),
    .dir  (dir),
    .geom (geom)
  );

  rti_classify u_class (
    .clk        (clk),
    .en         (adv),
    .geom       (geom),
    .par_thresh (par_thresh),
    .dv         (chain[0])
  );

  // Restoring division, most significant quotient bit first.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    rti_div_stage #(.BIT(DIV_STEPS - 1 - j)) u_step (
      .clk  (clk),
      .en   (adv),
      .din  (chain[j]),
      .dout (chain[j+1])
    );
  end

  // Floor and ceiling of t from the magnitude quotient; the window is tested
  // exactly on these, which is the same as testing t itself.
  always_comb begin
    rest   = |chain[DIV_STEPS].rt;
    qx     = XW'(chain[DIV_STEPS].qt) + XW'(rest);
    if (chain[DIV_STEPS].tneg) begin
      tf = -$signed(qx);
      tc = -$signed(XW'(chain[DIV_STEPS].qt));
    end else begin
      tf = $signed(XW'(chain[DIV_STEPS].qt));
      tc = $signed(qx);
    end
    win_ok = !chain[DIV_STEPS].miss && (tf >= XW'(tmin)) && (tc <= XW'(tmax));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit          <= win_ok;
      hit_distance <= win_ok ? tf[TW-1:0] : '0;
      bary_u       <= win_ok ? chain[DIV_STEPS].qu : '0;
      bary_v       <= win_ok ? chain[DIV_STEPS].qv : '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rti_geom.sv
`default_nettype none

module rti_geom (
  input  logic          clk,
  input  logic          en,
  input  rti_pkg::vec_t v0,
  input  rti_pkg::vec_t v1,
  input  rti_pkg::vec_t v2,
  input  rti_pkg::vec_t org,
  input  rti_pkg::vec_t dir,
  output rti_pkg::geom_t geom
);
  import rti_pkg::*;

  logic signed [CW-1:0] a0 [3];
  logic signed [CW-1:0] a1 [3];
  logic signed [CW-1:0] a2 [3];
  logic signed [CW-1:0] ao [3];
  logic signed [CW-1:0] ad [3];

  // Stage 1: edges and origin offset.
  logic signed [EW-1:0] e1_1 [3];
  logic signed [EW-1:0] e2_1 [3];
  logic signed [EW-1:0] s_1 [3];
  logic signed [EW-1:0] d_1 [3];
  // Stage 2: cross product terms.
  logic signed [PW-1:0] pa_2 [3];
  logic signed [PW-1:0] pb_2 [3];
  logic signed [PW-1:0] qa_2 [3];
  logic signed [PW-1:0] qb_2 [3];
  logic signed [EW-1:0] e1_2 [3];
  logic signed [EW-1:0] e2_2 [3];
  logic signed [EW-1:0] s_2 [3];
  logic signed [EW-1:0] d_2 [3];
  // Stage 3: cross products.
  logic signed [PW-1:0] p_3 [3];
  logic signed [PW-1:0] q_3 [3];
  logic signed [EW-1:0] e1_3 [3];
  logic signed [EW-1:0] e2_3 [3];
  logic signed [EW-1:0] s_3 [3];
  logic signed [EW-1:0] d_3 [3];
  // Stage 4: split dot product terms.
  logic signed [EW-1:0] aop [4][3];
  logic signed [PW-1:0] bop [4][3];
  logic signed [EW+PHW-1:0] mh_4 [4][3];
  logic signed [EW+PLW:0] ml_4 [4][3];
  // Stage 5 and 6.
  logic signed [AW-1:0] tm_5 [4][3];
  logic signed [AW-1:0] dot_6 [4];

  assign a0 = '{v0.x, v0.y, v0.z};
  assign a1 = '{v1.x, v1.y, v1.z};
  assign a2 = '{v2.x, v2.y, v2.z};
  assign ao = '{org.x, org.y, org.z};
  assign ad = '{dir.x, dir.y, dir.z};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_1[i] <= EW'(a1[i]) - EW'(a0[i]);
        e2_1[i] <= EW'(a2[i]) - EW'(a0[i]);
        s_1[i]  <= EW'(ao[i]) - EW'(a0[i]);
        d_1[i]  <= EW'(ad[i]);
      end
    end
  end

  // p = d x e2, q = s x e1
  always_ff @(posedge clk) begin
    if (en) begin
      pa_2[0] <= d_1[1] * e2_1[2];
      pb_2[0] <= d_1[2] * e2_1[1];
      pa_2[1] <= d_1[2] * e2_1[0];
      pb_2[1] <= d_1[0] * e2_1[2];
      pa_2[2] <= d_1[0] * e2_1[1];
      pb_2[2] <= d_1[1] * e2_1[0];
      qa_2[0] <= s_1[1] * e1_1[2];
      qb_2[0] <= s_1[2] * e1_1[1];
      qa_2[1] <= s_1[2] * e1_1[0];
      qb_2[1] <= s_1[0] * e1_1[2];
      qa_2[2] <= s_1[0] * e1_1[1];
      qb_2[2] <= s_1[1] * e1_1[0];
      e1_2 <= e1_1;
      e2_2 <= e2_1;
      s_2  <= s_1;
      d_2  <= d_1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_3[i] <= pa_2[i] - pb_2[i];
        q_3[i] <= qa_2[i] - qb_2[i];
      end
      e1_3 <= e1_2;
      e2_3 <= e2_2;
      s_3  <= s_2;
      d_3  <= d_2;
    end
  end

  // det = e1.p, un = s.p, vn = d.q, tn = e2.q
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aop[0][i] = e1_3[i];
      bop[0][i] = p_3[i];
      aop[1][i] = s_3[i];
      bop[1][i] = p_3[i];
      aop[2][i] = d_3[i];
      bop[2][i] = q_3[i];
      aop[3][i] = e2_3[i];
      bop[3][i] = q_3[i];
    end
  end

  // Each wide product is cut into a signed high part and an unsigned low part.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          mh_4[k][i] <= aop[k][i] * $signed(bop[k][i][PW-1:PLW]);
          ml_4[k][i] <= aop[k][i] * $signed({1'b0, bop[k][i][PLW-1:0]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          tm_5[k][i] <= (AW'(mh_4[k][i]) <<< PLW) + AW'(ml_4[k][i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        dot_6[k] <= tm_5[k][0] + tm_5[k][1] + tm_5[k][2];
      end
    end
  end

  assign geom.det = dot_6[0];
  assign geom.un  = dot_6[1];
  assign geom.vn  = dot_6[2];
  assign geom.tn  = dot_6[3];

endmodule

`default_nettype wire

>>> rtl/rti_classify.sv
`default_nettype none

module rti_classify (
  input  logic                    clk,
  input  logic                    en,
  input  rti_pkg::geom_t          geom,
  input  logic [rti_pkg::LW-1:0]  par_thresh,
  output rti_pkg::div_t           dv
);
  import rti_pkg::*;

  logic              neg;
  logic signed [AW-1:0] dn;
  logic signed [AW-1:0] un_n;
  logic signed [AW-1:0] vn_n;
  logic signed [AW-1:0] tn_n;

  // Stage 7: sign fold and bound tests.
  logic [AW-1:0] dvs_7, un_7, vn_7, tm_7;
  logic          tneg_7, fail_7, big_7;
  logic [SQW-1:0] a_7;
  // Stage 8: squared determinant partials and t range.
  logic [AW-1:0] dvs_8, un_8, vn_8, tm_8;
  logic          tneg_8, fail_8, big_8;
  logic [SQW-1:0] hh_8, hl_8, ll_8;
  // Stage 9.
  logic [AW-1:0] dvs_9, un_9, vn_9, tm_9;
  logic          tneg_9, fail_9, big_9;
  logic [LW-1:0] sq_9;
  // Stage 10.
  div_t          dv_10;

  always_comb begin
    neg  = geom.det[AW-1];
    dn   = neg ? -geom.det : geom.det;
    un_n = neg ? -geom.un : geom.un;
    vn_n = neg ? -geom.vn : geom.vn;
    tn_n = neg ? -geom.tn : geom.tn;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_7  <= dn;
      un_7   <= un_n;
      vn_7   <= vn_n;
      tneg_7 <= tn_n[AW-1];
      tm_7   <= tn_n[AW-1] ? -tn_n : tn_n;
      fail_7 <= (geom.det == '0) || un_n[AW-1] || (un_n > dn) || vn_n[AW-1]
                || ((un_n + vn_n) > dn);
      // Above this magnitude det squared exceeds any threshold.
      big_7  <= |dn[AW-1:SQW];
      a_7    <= dn[SQW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh_8   <= a_7[SQW-1:SQH] * a_7[SQW-1:SQH];
      hl_8   <= a_7[SQW-1:SQH] * a_7[SQH-1:0];
      ll_8   <= a_7[SQH-1:0] * a_7[SQH-1:0];
      dvs_8  <= dvs_7;
      un_8   <= un_7;
      vn_8   <= vn_7;
      tm_8   <= tm_7;
      tneg_8 <= tneg_7;
      // The t quotient must fit in the width of the window.
      fail_8 <= fail_7 || (RW'({tm_7, FRAC'(0)}) >= {dvs_7, TW'(0)});
      big_8  <= big_7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_9   <= (LW'(hh_8) << SQW) + (LW'(hl_8) << (SQH + 1)) + LW'(ll_8);
      dvs_9  <= dvs_8;
      un_9   <= un_8;
      vn_9   <= vn_8;
      tm_9   <= tm_8;
      tneg_9 <= tneg_8;
      fail_9 <= fail_8;
      big_9  <= big_8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_10.miss <= fail_9 || (!big_9 && (sq_9 < par_thresh));
      dv_10.tneg <= tneg_9;
      dv_10.dvs  <= dvs_9;
      dv_10.ru   <= RW'({un_9, FRAC'(0)});
      dv_10.rv   <= RW'({vn_9, FRAC'(0)});
      dv_10.rt   <= RW'({tm_9, FRAC'(0)});
      dv_10.qu   <= '0;
      dv_10.qv   <= '0;
      dv_10.qt   <= '0;
    end
  end

  assign dv = dv_10;

endmodule

`default_nettype wire

>>> rtl/rti_div_stage.sv
`default_nettype none

module rti_div_stage #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  rti_pkg::div_t din,
  output rti_pkg::div_t dout
);
  import rti_pkg::*;

  logic [RW-1:0] shd;
  logic          ge_t;
  div_t          nxt;
  div_t          q;

  assign shd  = RW'(din.dvs) << BIT;
  assign ge_t = din.rt >= shd;

  generate
    if (BIT < UQW) begin : g_uv
      logic ge_u, ge_v;
      assign ge_u = din.ru >= shd;
      assign ge_v = din.rv >= shd;
      always_comb begin
        nxt         = din;
        nxt.rt      = ge_t ? din.rt - shd : din.rt;
        nxt.qt[BIT] = ge_t;
        nxt.ru      = ge_u ? din.ru - shd : din.ru;
        nxt.qu[BIT] = ge_u;
        nxt.rv      = ge_v ? din.rv - shd : din.rv;
        nxt.qv[BIT] = ge_v;
      end
    end else begin : g_t
      always_comb begin
        nxt         = din;
        nxt.rt      = ge_t ? din.rt - shd : din.rt;
        nxt.qt[BIT] = ge_t;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

  assign dout = q;

endmodule

`default_nettype wire

>>> rtl/rti_checker.sv
`default_nettype none

module rti_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        hit,
  input logic signed [rti_pkg::TW-1:0] hit_distance,
  input logic [rti_pkg::UQW-1:0]     bary_u,
  input logic [rti_pkg::UQW-1:0]     bary_v
);
  import rti_pkg::*;

  localparam logic [UQW:0] ONE = (UQW+1)'(1) << FRAC;

  // A result waiting for the receiver stays up.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The pipe takes a new beat exactly when it can advance.
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_distance == '0 && bary_u == '0 && bary_v == '0)
    else $error("miss with nonzero fields");

  a_bary_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> ((UQW+1)'(bary_u) + (UQW+1)'(bary_v)) <= ONE)
    else $error("barycentric sum above one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind ray_triangle_intersect_core rti_checker u_rti_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .hit          (hit),
  .hit_distance (hit_distance),
  .bary_u       (bary_u),
  .bary_v       (bary_v)
);

`default_nettype wire

>>> sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rti_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] tdist;
    logic [16:0]        u;
    logic [16:0]        v;
  } hit_rec_t;

  // Keeps its own copy of the ray registers and predicts one hit record per
  // triangle from exact wide arithmetic; the queue holds records in flight.
  class hit_scoreboard;
    logic [31:0] ray_regs[8];
    hit_rec_t    awaited[$];
    int          faults;

    function new();
      foreach (ray_regs[i]) ray_regs[i] = '0;
      ray_regs[REG_DIR_Z]    = 32'd256;
      ray_regs[REG_MAX_DIST] = 32'h7FFF_FFFF;
      faults = 0;
    endfunction

    function void write_reg(logic [IDXW-1:0] idx, logic [31:0] value);
      if (idx <= REG_MAX_DIST)
        ray_regs[idx] = (idx < REG_MIN_DIST) ? {8'd0, value[23:0]} : value;
    endfunction

    function wide_t coord(int i);
      return $signed(ray_regs[i][23:0]);
    endfunction

    function void cross3(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function void note_triangle(coord_t vtx[9]);
      wide_t p0[3], e1[3], e2[3], d[3], s[3], pv[3], qv[3];
      wide_t det, un, vn, tn, dd, ts, tmin, tmax, q, eps2;
      hit_rec_t r;
      r = '{0, 0, 0, 0};
      for (int i = 0; i < 3; i++) begin
        p0[i] = vtx[i];
        e1[i] = vtx[3+i] - p0[i];
        e2[i] = vtx[6+i] - p0[i];
        d[i]  = coord(3 + i);
        s[i]  = coord(i) - p0[i];
      end
      tmin = $signed(ray_regs[REG_MIN_DIST]);
      tmax = $signed(ray_regs[REG_MAX_DIST]);
      cross3(d, e2, pv);
      cross3(s, e1, qv);
      det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
      un  = s[0] * pv[0] + s[1] * pv[1] + s[2] * pv[2];
      vn  = d[0] * qv[0] + d[1] * qv[1] + d[2] * qv[2];
      tn  = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
      dd  = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
      eps2 = EPS_DEFAULT * EPS_DEFAULT;
      // Any early exit below is a miss, which reports all fields as zero.
      if (det != 0 && det * det >= eps2 * dd) begin
        if (det < 0) begin
          det = -det; un = -un; vn = -vn; tn = -tn;
        end
        ts = tn <<< 16;
        if (un >= 0 && un <= det && vn >= 0 && un + vn <= det &&
            ts >= tmin * det && ts <= tmax * det) begin
          r.hit = 1'b1;
          q = (un <<< 16) / det;
          r.u = q[16:0];
          q = (vn <<< 16) / det;
          r.v = q[16:0];
          // Round toward minus infinity on both sides of zero.
          q = (ts < 0) ? -((-ts + det - 1) / det) : ts / det;
          r.tdist = q[31:0];
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_result(logic h, logic signed [31:0] tdist, logic [16:0] u,
                               logic [16:0] v);
      hit_rec_t e;
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result beat: hit=%0b t=%0d", h, tdist);
        return;
      end
      e = awaited.pop_front();
      if (e.hit !== h || e.tdist !== tdist || e.u !== u || e.v !== v) begin
        faults++;
        if (faults <= 10)
          $display("result differs: exp hit=%0b t=%0d u=%0d v=%0d, got hit=%0b t=%0d u=%0d v=%0d",
                   e.hit, e.tdist, e.u, e.v, h, tdist, u, v);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [IDXW-1:0] cfg_index;
  logic [DATAW-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  coord_t vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z;
  coord_t vertex2_x, vertex2_y, vertex2_z;
  logic hit;
  logic signed [TW-1:0] hit_distance;
  logic [UQW-1:0] bary_u, bary_v;

  hit_scoreboard sb = new();
  bit   hold_request = 0;
  int   burst_left = 0;

  ray_triangle_intersect_core dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .vertex0_x, .vertex0_y, .vertex0_z, .vertex1_x, .vertex1_y, .vertex1_z,
    .vertex2_x, .vertex2_y, .vertex2_z,
    .out_valid, .out_ready, .hit, .hit_distance, .bary_u, .bary_v
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver switches at random between stall patterns: always ready,
  // ready at random, or ready only one cycle in four. A long hold-off, asked
  // for by the stimulus, lets the pipeline fill and push back on the sender.
  initial begin
    int cyc, pattern, hold_left;
    cyc = 0; pattern = 0; hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready && !rst)
        sb.check_result(hit, hit_distance, bary_u, bary_v);
      if (hold_request && hold_left == 0) begin
        hold_request = 0;
        hold_left = 300;
      end
      cyc++;
      if (cyc % 64 == 0) pattern = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (pattern)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (cyc % 4 == 0);
        endcase
      end
    end
  end

  // The watchdog ends the run when no beat of any kind has moved for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet == 3000) begin
        $display("ray_triangle_intersect_core: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [IDXW-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one triangle and waits for its beat. Within a burst in_valid stays
  // high; when a burst runs out the sender may go quiet for a random gap.
  task automatic send_triangle(coord_t vtx[9]);
    in_valid  <= 1'b1;
    vertex0_x <= vtx[0]; vertex0_y <= vtx[1]; vertex0_z <= vtx[2];
    vertex1_x <= vtx[3]; vertex1_y <= vtx[4]; vertex1_z <= vtx[5];
    vertex2_x <= vtx[6]; vertex2_y <= vtx[7]; vertex2_z <= vtx[8];
    do @(posedge clk); while (!in_ready);
    sb.note_triangle(vtx);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // Waits for every result in flight, then lets the pipeline drain fully
  // before the registers change under it.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  function automatic coord_t clamp24(longint x);
    if (x > 8388607) return 24'sh7FFFFF;
    if (x < -8388608) return 24'sh800000;
    return coord_t'(x);
  endfunction

  function automatic int spread(int r);
    return $urandom_range(0, 2 * r) - r;
  endfunction

  // Most triangles are built round a point on the ray so that hits and the
  // bound tests near the edges are common; the rest are raw random vertices.
  task automatic random_triangles(int n);
    coord_t vtx[9];
    longint t, ctr;
    int r;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 6) begin
        t = spread(3) + 6;
        r = ($urandom_range(0, 3) == 0) ? 40 : 3000;
        for (int c = 0; c < 3; c++) begin
          ctr = longint'(sb.coord(c)) + t * longint'(sb.coord(3 + c));
          for (int j = 0; j < 3; j++) vtx[3*j+c] = clamp24(ctr + spread(r));
        end
      end else begin
        foreach (vtx[j]) vtx[j] = coord_t'($urandom());
      end
      send_triangle(vtx);
      if (k == n / 2 && n > 100) hold_request = 1;
    end
  endtask

  task automatic directed_triangles();
    coord_t set[12][9] = '{
      '{-256, -256, 512, 512, -256, 512, -256, 512, 512},        // centre hit
      '{0, 0, 256, 256, 0, 256, 0, 256, 256},                    // through vertex 0
      '{-256, 0, 256, 0, 0, 256, -256, 256, 256},                // u exactly one
      '{-256, -256, 256, 256, -256, 256, -256, 256, 256},        // on edge u+v=1
      '{-256, -256, 512, -256, 512, 512, 512, -256, 512},        // reversed winding
      '{-256, -256, -512, 512, -256, -512, -256, 512, -512},     // behind the origin
      '{0, 0, 0, 0, 0, 256, 256, 0, 0},                          // parallel to the ray
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},                              // degenerate triangle
      '{8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
        8388607, 8388607, 8388607},
      '{-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
        -8388608, -8388608, -8388608},
      '{-8388608, -8388608, 8388607, 8388607, -8388608, 8388607,
        -8388608, 8388607, 8388607},                             // huge triangle
      '{1000, 1000, 256, 2000, 1000, 256, 1000, 2000, 256}       // off to the side
    };
    foreach (set[i]) send_triangle(set[i]);
  endtask

  initial begin
    logic [31:0] val[8];
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    {vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z} = '0;
    {vertex2_x, vertex2_y, vertex2_z} = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset ray straight along +z with the window [0, max].
    directed_triangles();
    random_triangles(120);

    for (int ph = 1; ph <= 5; ph++) begin
      drain();
      case (ph)
        1: begin  // modest random ray
          for (int c = 0; c < 3; c++) val[c] = spread(4096);
          for (int c = 3; c < 6; c++) val[c] = spread(1024);
          val[6] = spread(1 << 18);
          val[7] = 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
        end
        2: begin  // extreme ray and the full window
          val = '{32'h7F_FFFF, 32'h80_0000, 32'h7F_FFFF, 32'h80_0000, 32'h7F_FFFF,
                  32'h80_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        end
        3: begin  // empty window
          for (int c = 0; c < 6; c++) val[c] = spread(512);
          val[6] = 32'd65536;
          val[7] = 32'd65535;
        end
        4: begin  // zero direction
          for (int c = 0; c < 3; c++) val[c] = spread(2048);
          for (int c = 3; c < 6; c++) val[c] = '0;
          val[6] = 32'h8000_0000;
          val[7] = 32'h7FFF_FFFF;
        end
        default: begin  // raw register contents, high bits ignored
          for (int c = 0; c < 6; c++) val[c] = $urandom();
          val[6] = $urandom();
          val[7] = $urandom();
        end
      endcase
      foreach (val[r]) write_reg(reg_idx_t'(r), val[r]);
      if (ph == 5) write_reg(4'd12, $urandom());  // unused index, dropped
      if (ph == 2) directed_triangles();
      random_triangles(ph == 1 ? 200 : 120);
    end

    drain();
    if (sb.faults == 0)
      $display("ray_triangle_intersect_core: match");
    else
      $display("ray_triangle_intersect_core: mismatch");
    $finish;
  end

endmodule

>>> sim.f
rtl/rti_pkg.sv
rtl/rti_geom.sv
rtl/rti_classify.sv
rtl/rti_div_stage.sv
rtl/ray_triangle_intersect_core.sv
rtl/rti_checker.sv
sim/tb_top.sv
